// File: rtl/bhq_pkg.sv
// Shared types, constants and helpers for the binary min-heap queue.
package bhq_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W = 32;
	localparam int PAYLOAD_W = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = CNT_W;
	localparam int KID_W = POS_W + 1;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_FULL,
		STATUS_EMPTY
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_POP_LAST,
		ST_POP_L,
		ST_POP_R,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAYLOAD_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		logic op;
		logic [KEY_W-1:0] new_key;
		logic [PAYLOAD_W-1:0] new_payload;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] top_key;
		logic [PAYLOAD_W-1:0] top_payload;
		logic [CNT_W-1:0] entry_count;
		logic [KEY_W-1:0] popped_key;
		logic [PAYLOAD_W-1:0] popped_payload;
		status_t status;
	} res_t;

	// Heap positions run from 1 to CAPACITY; the memory is addressed from 0.
	function automatic logic [ADDR_W-1:0] pos_to_addr(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] a;
		a = pos - POS_W'(1);
		return a[ADDR_W-1:0];
	endfunction

endpackage

// File: rtl/bhq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/binary_min_heap_queue.sv
// Top level of the binary min-heap priority queue core.
//
// Usage: present a request on req and raise start; the transaction is taken at
// the rising edge where start is high and busy is low. An insert (op 0) adds
// new_key/new_payload; a pop (op 1) removes the entry with the smallest key.
// Exactly one result follows each request: it sits on res for one cycle while
// done is high, and the receiver takes it at that edge without any way to stall.
// busy stays high from the accepting edge through the done cycle, so one request
// is in flight at a time.
// The heap lives in one memory with a registered read port, and every level
// of a sift costs a read-compare-write. An insert compares with the parent
// once for each level climbed. A pop first reads the last entry, then for
// each level reads the left child and any right child and compares them,
// and a sift that reaches the root or a leaf ends with one extra write.
// Refused and trivial requests (full insert, empty pop, pop of the last
// entry, insert into an empty heap) go straight from idle to done.
// The root entry is mirrored in a register, so the top fields need no extra read.
// Reset clears the entry count and the controller; the memory is not cleared
// and needs no clearing pass, since only occupied positions are ever read.
module binary_min_heap_queue_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bhq_pkg::req_t req,
	output logic          done,
	output bhq_pkg::res_t res
);

	bhq_pkg::state_t state_q, state_d;
	logic [bhq_pkg::CNT_W-1:0] count_q, count_d;
	logic [bhq_pkg::POS_W-1:0] pos_q, pos_d;
	logic [bhq_pkg::KID_W-1:0] kid_q, kid_d;
	bhq_pkg::entry_t mov_q, mov_d;
	bhq_pkg::entry_t left_q, left_d;
	bhq_pkg::entry_t root_q;
	bhq_pkg::entry_t popped_q, popped_d;
	bhq_pkg::status_t status_q, status_d;

	logic we;
	logic [bhq_pkg::ADDR_W-1:0] waddr, raddr;
	bhq_pkg::entry_t wdata, rdata;

	bhq_ram #(
		.WIDTH($bits(bhq_pkg::entry_t)),
		.DEPTH(bhq_pkg::CAPACITY)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic take_right, decide;
	bhq_pkg::entry_t cand;
	logic [bhq_pkg::KID_W-1:0] cand_pos, next_kid, kid_inc, count_ext;
	logic [bhq_pkg::POS_W-1:0] new_pos, up_pos;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pos_d = pos_q;
		kid_d = kid_q;
		mov_d = mov_q;
		left_d = left_q;
		popped_d = popped_q;
		status_d = status_q;
		we = 1'b0;
		waddr = '0;
		wdata = mov_q;
		raddr = '0;

		count_ext = {1'b0, count_q};
		kid_inc = kid_q + bhq_pkg::KID_W'(1);
		new_pos = count_q + bhq_pkg::POS_W'(1);
		up_pos = pos_q >> 1;
		take_right = (state_q == bhq_pkg::ST_POP_R) && (left_q.key > rdata.key);
		if (state_q == bhq_pkg::ST_POP_L || take_right) begin
			cand = rdata;
		end else begin
			cand = left_q;
		end
		cand_pos = take_right ? kid_inc : kid_q;
		next_kid = {cand_pos[bhq_pkg::POS_W-1:0], 1'b0};
		decide = 1'b0;

		case (state_q)
			bhq_pkg::ST_IDLE: begin
				if (start) begin
					popped_d = '0;
					status_d = bhq_pkg::STATUS_OK;
					state_d = bhq_pkg::ST_DONE;
					if (req.op == bhq_pkg::OP_INSERT) begin
						if (count_q == bhq_pkg::CAP_CNT) begin
							status_d = bhq_pkg::STATUS_FULL;
						end else begin
							count_d = new_pos;
							pos_d = new_pos;
							mov_d = '{key: req.new_key, payload: req.new_payload};
							if (new_pos == bhq_pkg::POS_W'(1)) begin
								we = 1'b1;
								waddr = bhq_pkg::pos_to_addr(new_pos);
								wdata = '{key: req.new_key, payload: req.new_payload};
							end else begin
								raddr = bhq_pkg::pos_to_addr(new_pos >> 1);
								state_d = bhq_pkg::ST_INS_CMP;
							end
						end
					end else begin
						if (count_q == '0) begin
							status_d = bhq_pkg::STATUS_EMPTY;
						end else begin
							popped_d = root_q;
							count_d = count_q - bhq_pkg::CNT_W'(1);
							if (count_q != bhq_pkg::CNT_W'(1)) begin
								raddr = bhq_pkg::pos_to_addr(count_q);
								state_d = bhq_pkg::ST_POP_LAST;
							end
						end
					end
				end
			end
			bhq_pkg::ST_INS_CMP: begin
				we = 1'b1;
				waddr = bhq_pkg::pos_to_addr(pos_q);
				if (rdata.key > mov_q.key) begin
					// Parent moves down one level; keep climbing or place at the root.
					wdata = rdata;
					pos_d = up_pos;
					if (up_pos == bhq_pkg::POS_W'(1)) begin
						state_d = bhq_pkg::ST_FIN;
					end else begin
						raddr = bhq_pkg::pos_to_addr(up_pos >> 1);
					end
				end else begin
					wdata = mov_q;
					state_d = bhq_pkg::ST_DONE;
				end
			end
			bhq_pkg::ST_POP_LAST: begin
				mov_d = rdata;
				pos_d = bhq_pkg::POS_W'(1);
				kid_d = bhq_pkg::KID_W'(2);
				if (bhq_pkg::KID_W'(2) <= count_ext) begin
					raddr = bhq_pkg::pos_to_addr(bhq_pkg::POS_W'(2));
					state_d = bhq_pkg::ST_POP_L;
				end else begin
					we = 1'b1;
					waddr = bhq_pkg::pos_to_addr(bhq_pkg::POS_W'(1));
					wdata = rdata;
					state_d = bhq_pkg::ST_DONE;
				end
			end
			bhq_pkg::ST_POP_L: begin
				left_d = rdata;
				if (kid_q < count_ext) begin
					raddr = bhq_pkg::pos_to_addr(kid_inc[bhq_pkg::POS_W-1:0]);
					state_d = bhq_pkg::ST_POP_R;
				end else begin
					decide = 1'b1;
				end
			end
			bhq_pkg::ST_POP_R: begin
				decide = 1'b1;
			end
			bhq_pkg::ST_FIN: begin
				we = 1'b1;
				waddr = bhq_pkg::pos_to_addr(pos_q);
				wdata = mov_q;
				state_d = bhq_pkg::ST_DONE;
			end
			bhq_pkg::ST_DONE: begin
				state_d = bhq_pkg::ST_IDLE;
			end
			default: begin
				state_d = bhq_pkg::ST_IDLE;
			end
		endcase

		// Sift-down step: the moving entry stops only where its smaller child is strictly greater.
		if (decide) begin
			we = 1'b1;
			waddr = bhq_pkg::pos_to_addr(pos_q);
			if (cand.key > mov_q.key) begin
				wdata = mov_q;
				state_d = bhq_pkg::ST_DONE;
			end else begin
				wdata = cand;
				pos_d = cand_pos[bhq_pkg::POS_W-1:0];
				kid_d = next_kid;
				if (next_kid <= count_ext) begin
					raddr = bhq_pkg::pos_to_addr(next_kid[bhq_pkg::POS_W-1:0]);
					state_d = bhq_pkg::ST_POP_L;
				end else begin
					state_d = bhq_pkg::ST_FIN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhq_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		kid_q <= kid_d;
		mov_q <= mov_d;
		left_q <= left_d;
		popped_q <= popped_d;
		status_q <= status_d;
		if (we && waddr == '0) begin
			root_q <= wdata;
		end
	end

	assign busy = (state_q != bhq_pkg::ST_IDLE);
	assign done = (state_q == bhq_pkg::ST_DONE);

	always_comb begin
		res.top_key = (count_q != '0) ? root_q.key : '0;
		res.top_payload = (count_q != '0) ? root_q.payload : '0;
		res.entry_count = count_q;
		res.popped_key = popped_q.key;
		res.popped_payload = popped_q.payload;
		res.status = status_q;
	end

endmodule

// File: rtl/bhq_checker.sv
// Port-level checks for the heap queue core, bound to its top level.
module bhq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input bhq_pkg::req_t req,
	input logic          done,
	input bhq_pkg::res_t res
);

	// An accepted transaction keeps the core busy until its result is shown.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("core not busy after accepting a request");

	// A result strobe lasts exactly one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// A refused insert is only reported on a full heap.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status == bhq_pkg::STATUS_FULL) |->
		(res.entry_count == bhq_pkg::CAP_CNT))
		else $error("full status with spare capacity");

	// A refused request never reports a removed entry.
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status != bhq_pkg::STATUS_OK) |->
		(res.popped_key == '0 && res.popped_payload == '0))
		else $error("refused request reports a popped entry");

	// The count never exceeds the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.entry_count <= bhq_pkg::CAP_CNT))
		else $error("entry count beyond capacity");

endmodule

bind binary_min_heap_queue_core bhq_checker u_bhq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.req(req),
	.done(done),
	.res(res)
);
